// ===== src/dbl_pkg.sv =====
// Shared widths, register indexes and stage structs for the Dalitz boundary block.
package dbl_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS_DEF = 20;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASS_I      = 2'd0,
    REG_MASS_J      = 2'd1,
    REG_MASS_K      = 2'd2,
    REG_PARENT_MASS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              zero;
    logic [WORD_W-1:0] s;
  } root_side_t;

  typedef struct packed {
    logic fail;
    logic neg;
  } div_side_t;

  typedef struct packed {
    logic              fail;
    logic [WORD_W-1:0] esum_mag;
  } mom_side_t;

  typedef struct packed {
    logic [WORD_W-1:0] limit_low;
    logic [WORD_W-1:0] limit_high;
    logic              unphysical;
  } result_t;

endpackage

// ===== src/dbl_channels.sv =====
// Valid/ready channel interfaces for pair mass input and limit results.
interface dbl_pair_if import dbl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] pair_mass_sq;
  modport source (output valid, output pair_mass_sq, input ready);
  modport sink (input valid, input pair_mass_sq, output ready);
endinterface

interface dbl_limits_if import dbl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] limit_low;
  logic [WORD_W-1:0] limit_high;
  logic              unphysical;
  modport source (output valid, output limit_low, output limit_high, output unphysical,
                  input ready);
  modport sink (input valid, input limit_low, input limit_high, input unphysical,
                output ready);
endinterface

// ===== src/dbl_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module dbl_sqrt import dbl_pkg::*; #(
  parameter int W      = WORD_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*W-1:0]    radicand,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [W-1:0]      root,
  output logic [SIDE_W-1:0] side_out
);

  logic [2*W-1:0]    v_q    [W];
  logic [2*W-1:0]    r_q    [W];
  logic [SIDE_W-1:0] side_q [W];
  logic              vld_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam logic [2*W-1:0] BIT = (2*W)'(1) << (2*W-2-2*k);
    logic [2*W-1:0]    v_in, r_in, v_next, r_next, trial;
    logic [SIDE_W-1:0] s_in;
    logic              vl_in;

    if (k == 0) begin : g_first
      assign v_in  = radicand;
      assign r_in  = '0;
      assign s_in  = side_in;
      assign vl_in = in_valid;
    end else begin : g_rest
      assign v_in  = v_q[k-1];
      assign r_in  = r_q[k-1];
      assign s_in  = side_q[k-1];
      assign vl_in = vld_q[k-1];
    end

    always_comb begin
      trial = r_in + BIT;
      if (v_in >= trial) begin
        v_next = v_in - trial;
        r_next = (r_in >> 1) + BIT;
      end else begin
        v_next = v_in;
        r_next = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[k]    <= v_next;
        r_q[k]    <= r_next;
        side_q[k] <= s_in;
      end
    end
  end

  assign out_valid = vld_q[W-1];
  assign root      = r_q[W-1][W-1:0];
  assign side_out  = side_q[W-1];

endmodule

// ===== src/dbl_div.sv =====
// Pipelined restoring divider, 2W by W bits, one quotient bit per stage.
module dbl_div import dbl_pkg::*; #(
  parameter int W      = WORD_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*W-1:0]    dividend,
  input  logic [W-1:0]      divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [W-1:0]      quotient,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);

  logic [W-1:0]      rem_q  [W+1];
  logic [W-1:0]      low_q  [W+1];
  logic [W-1:0]      d_q    [W+1];
  logic [W-1:0]      quo_q  [W+1];
  logic              ovf_q  [W+1];
  logic [SIDE_W-1:0] side_q [W+1];
  logic              vld_q  [W+1];

  // quotient needs more than W bits when the high half is not below the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= dividend[2*W-1:W];
      low_q[0]  <= dividend[W-1:0];
      d_q[0]    <= divisor;
      quo_q[0]  <= '0;
      ovf_q[0]  <= dividend[2*W-1:W] >= divisor;
      side_q[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_stage
    logic [W:0] t, diff;
    logic       ge;

    always_comb begin
      t    = {rem_q[k-1], low_q[k-1][W-1]};
      diff = t - {1'b0, d_q[k-1]};
      ge   = t >= {1'b0, d_q[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[W-1:0] : t[W-1:0];
        low_q[k]  <= {low_q[k-1][W-2:0], 1'b0};
        d_q[k]    <= d_q[k-1];
        quo_q[k]  <= {quo_q[k-1][W-2:0], ge};
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid = vld_q[W];
  assign quotient  = quo_q[W];
  assign ovf       = ovf_q[W];
  assign side_out  = side_q[W];

endmodule

// ===== src/dalitz_boundary_limits_core.sv =====
// Dalitz plot boundary limits of s_jk for a three-body decay, pipelined.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------
//  pair     | in  | valid / ready | pair_mass_sq
//  limits   | out | valid / ready | limit_low, limit_high, unphysical
//  cfg      | in  | cfg_we        | cfg_index, cfg_data (no read-back)
//
// One transaction per cycle while the output buffer has room; the pipeline has the
// 32-step s_ij root, the 33-step energy dividers and the 32-step momentum roots.
// Synchronous active-high reset clears valid bits and the output buffer.
// A two-entry output buffer lets input flow on while one result waits; the
// pipeline holds only when that buffer is full.
module dalitz_boundary_limits_core import dbl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  dbl_pair_if.sink             pair,
  dbl_limits_if.source         limits
);

  localparam int W  = WORD_W;
  localparam int F  = FRAC_BITS;
  localparam int DW = 2*W;
  localparam int NW = 2*W + 2;

  logic [W-1:0]  mass_i, mass_j, mass_k, parent_mass;
  logic [DW-1:0] sq_i, sq_j, sq_k, sq_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_i      <= '0;
      mass_j      <= '0;
      mass_k      <= '0;
      parent_mass <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MASS_I:      mass_i      <= cfg_data;
        REG_MASS_J:      mass_j      <= cfg_data;
        REG_MASS_K:      mass_k      <= cfg_data;
        REG_PARENT_MASS: parent_mass <= cfg_data;
        default:         mass_i      <= mass_i;
      endcase
    end
  end

  // mass squares follow; user must change masses only while idle, unenforced
  always_ff @(posedge clk) begin
    sq_i <= ({{W{1'b0}}, mass_i} * {{W{1'b0}}, mass_i}) >> F;
    sq_j <= ({{W{1'b0}}, mass_j} * {{W{1'b0}}, mass_j}) >> F;
    sq_k <= ({{W{1'b0}}, mass_k} * {{W{1'b0}}, mass_k}) >> F;
    sq_p <= ({{W{1'b0}}, parent_mass} * {{W{1'b0}}, parent_mass}) >> F;
  end

  logic       en;
  logic [1:0] buf_cnt;

  assign en         = buf_cnt != 2'd2;
  assign pair.ready = en;

  // stage A: input register
  logic         a_valid;
  logic [W-1:0] a_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s <= pair.pair_mass_sq;
    end
  end

  // root of s_ij
  root_side_t   r_side_in, r_side_out;
  logic         r_valid;
  logic [W-1:0] r_root;
  logic [DW-1:0] r_rad;

  assign r_rad     = {{W{1'b0}}, a_s} << F;
  assign r_side_in = '{zero: a_s == '0, s: a_s};

  dbl_sqrt #(.W(W), .SIDE_W($bits(root_side_t))) u_root_s (
    .clk, .rst, .en,
    .in_valid  (a_valid),
    .radicand  (r_rad),
    .side_in   (r_side_in),
    .out_valid (r_valid),
    .root      (r_root),
    .side_out  (r_side_out)
  );

  // stage C1: numerators and divisor
  logic          c1_valid, c1_zero;
  logic [NW-1:0] c1_nj, c1_nk;
  logic [W-1:0]  c1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (en) begin
      c1_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_zero <= r_side_out.zero;
      c1_d    <= {r_root[W-2:0], 1'b0};
      c1_nj   <= {{(NW-W){1'b0}}, r_side_out.s} - {2'b00, sq_i} + {2'b00, sq_j};
      c1_nk   <= {2'b00, sq_p} - {{(NW-W){1'b0}}, r_side_out.s} - {2'b00, sq_k};
    end
  end

  // stage C2: magnitude, sign, range, dividend
  logic [NW-1:0] mag_j, mag_k, shf_j, shf_k;
  logic          ovf_nj, ovf_nk;

  always_comb begin
    mag_j  = c1_nj[NW-1] ? (~c1_nj + 1'b1) : c1_nj;
    mag_k  = c1_nk[NW-1] ? (~c1_nk + 1'b1) : c1_nk;
    ovf_nj = (mag_j >> (DW-F)) != '0;
    ovf_nk = (mag_k >> (DW-F)) != '0;
    shf_j  = mag_j << F;
    shf_k  = mag_k << F;
  end

  logic          c2_valid;
  logic [DW-1:0] c2_dvd_j, c2_dvd_k;
  logic [W-1:0]  c2_d;
  div_side_t     c2_side_j, c2_side_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_valid <= 1'b0;
    end else if (en) begin
      c2_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_dvd_j  <= shf_j[DW-1:0];
      c2_dvd_k  <= shf_k[DW-1:0];
      c2_d      <= c1_d;
      c2_side_j <= '{fail: c1_zero | ovf_nj | ovf_nk, neg: c1_nj[NW-1]};
      c2_side_k <= '{fail: 1'b0, neg: c1_nk[NW-1]};
    end
  end

  // energy dividers
  logic         dj_valid, dk_valid, dj_ovf, dk_ovf;
  logic [W-1:0] q_j, q_k;
  div_side_t    dj_side, dk_side;

  dbl_div #(.W(W), .SIDE_W($bits(div_side_t))) u_div_j (
    .clk, .rst, .en,
    .in_valid  (c2_valid),
    .dividend  (c2_dvd_j),
    .divisor   (c2_d),
    .side_in   (c2_side_j),
    .out_valid (dj_valid),
    .quotient  (q_j),
    .ovf       (dj_ovf),
    .side_out  (dj_side)
  );

  dbl_div #(.W(W), .SIDE_W($bits(div_side_t))) u_div_k (
    .clk, .rst, .en,
    .in_valid  (c2_valid),
    .dividend  (c2_dvd_k),
    .divisor   (c2_d),
    .side_in   (c2_side_k),
    .out_valid (dk_valid),
    .quotient  (q_k),
    .ovf       (dk_ovf),
    .side_out  (dk_side)
  );

  // stage E1: signed energies, sum, energy squares
  logic [W:0]   ej, ek;
  logic [W+1:0] esum;

  always_comb begin
    ej   = dj_side.neg ? -{1'b0, q_j} : {1'b0, q_j};
    ek   = dk_side.neg ? -{1'b0, q_k} : {1'b0, q_k};
    esum = {ej[W], ej} + {ek[W], ek};
  end

  logic          e1_valid, e1_fail;
  logic [DW-1:0] e1_prod_j, e1_prod_k;
  logic [W+1:0]  e1_esum;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else if (en) begin
      e1_valid <= dj_valid & dk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_fail   <= dj_side.fail | dk_side.fail | dj_ovf | dk_ovf;
      e1_prod_j <= {{W{1'b0}}, q_j} * {{W{1'b0}}, q_j};
      e1_prod_k <= {{W{1'b0}}, q_k} * {{W{1'b0}}, q_k};
      e1_esum   <= esum;
    end
  end

  // stage E2: momentum root arguments
  logic [DW:0]   arg_j, arg_k;
  logic [DW-1:0] rad_j, rad_k;
  logic [W+1:0]  esum_mag;

  always_comb begin
    arg_j    = {1'b0, e1_prod_j >> F} - {1'b0, sq_j};
    arg_k    = {1'b0, e1_prod_k >> F} - {1'b0, sq_k};
    rad_j    = arg_j[DW-1:0] << F;
    rad_k    = arg_k[DW-1:0] << F;
    esum_mag = e1_esum[W+1] ? -e1_esum : e1_esum;
  end

  logic          e2_valid;
  logic [DW-1:0] e2_rad_j, e2_rad_k;
  mom_side_t     e2_side_j, e2_side_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
    end else if (en) begin
      e2_valid <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_rad_j  <= rad_j;
      e2_rad_k  <= rad_k;
      e2_side_j <= '{fail: e1_fail | arg_j[DW] | arg_k[DW] | (esum_mag[W+1:W] != 2'b00),
                     esum_mag: esum_mag[W-1:0]};
      e2_side_k <= '{fail: 1'b0, esum_mag: esum_mag[W-1:0]};
    end
  end

  // momentum roots
  logic         pj_valid, pk_valid;
  logic [W-1:0] p_j, p_k;
  mom_side_t    pj_side, pk_side;

  dbl_sqrt #(.W(W), .SIDE_W($bits(mom_side_t))) u_root_pj (
    .clk, .rst, .en,
    .in_valid  (e2_valid),
    .radicand  (e2_rad_j),
    .side_in   (e2_side_j),
    .out_valid (pj_valid),
    .root      (p_j),
    .side_out  (pj_side)
  );

  dbl_sqrt #(.W(W), .SIDE_W($bits(mom_side_t))) u_root_pk (
    .clk, .rst, .en,
    .in_valid  (e2_valid),
    .radicand  (e2_rad_k),
    .side_in   (e2_side_k),
    .out_valid (pk_valid),
    .root      (p_k),
    .side_out  (pk_side)
  );

  // stage G: momentum sum and difference
  logic [W:0] psum;

  assign psum = {1'b0, p_j} + {1'b0, p_k};

  logic         g_valid, g_fail;
  logic [W-1:0] g_esum, g_psum, g_pdiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= pj_valid & pk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_fail  <= pj_side.fail | pk_side.fail | psum[W];
      g_esum  <= pj_side.esum_mag | pk_side.esum_mag;
      g_psum  <= psum[W-1:0];
      g_pdiff <= (p_j > p_k) ? (p_j - p_k) : (p_k - p_j);
    end
  end

  // stage H: squares
  logic          h_valid, h_fail;
  logic [DW-1:0] h_esq, h_psq, h_dsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_fail <= g_fail;
      h_esq  <= {{W{1'b0}}, g_esum} * {{W{1'b0}}, g_esum};
      h_psq  <= {{W{1'b0}}, g_psum} * {{W{1'b0}}, g_psum};
      h_dsq  <= {{W{1'b0}}, g_pdiff} * {{W{1'b0}}, g_pdiff};
    end
  end

  // stage I: limits and range check
  logic [DW:0] lim_l, lim_h;
  logic        bad;
  result_t     i_res_next;

  always_comb begin
    lim_l = {1'b0, h_esq >> F} - {1'b0, h_psq >> F};
    lim_h = {1'b0, h_esq >> F} - {1'b0, h_dsq >> F};
    bad   = h_fail | lim_l[DW] | lim_h[DW] | (lim_h[DW-1:W] != '0);
    i_res_next.unphysical = bad;
    i_res_next.limit_low  = bad ? '0 : lim_l[W-1:0];
    i_res_next.limit_high = bad ? '0 : lim_h[W-1:0];
  end

  logic    i_valid;
  result_t i_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (en) begin
      i_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_res <= i_res_next;
    end
  end

  // output buffer, two entries
  result_t buf0, buf1;
  logic    push, pop;

  assign push = en & i_valid;
  assign pop  = limits.valid & limits.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   buf_cnt <= buf_cnt + 2'd1;
        2'b01:   buf_cnt <= buf_cnt - 2'd1;
        default: buf_cnt <= buf_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        buf0 <= i_res;
      end
      2'b01: begin
        buf0 <= buf1;
      end
      2'b10: begin
        if (buf_cnt == 2'd0) begin
          buf0 <= i_res;
        end else begin
          buf1 <= i_res;
        end
      end
      default: begin
        buf0 <= buf0;
      end
    endcase
  end

  assign limits.valid      = buf_cnt != 2'd0;
  assign limits.limit_low  = buf0.limit_low;
  assign limits.limit_high = buf0.limit_high;
  assign limits.unphysical = buf0.unphysical;

endmodule

// ===== src/dbl_checker.sv =====
// Port-level assertions for the Dalitz boundary core, with bind.
module dbl_checker import dbl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] limit_low,
  input logic [WORD_W-1:0] limit_high,
  input logic              unphysical
);

  a_unphys_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && unphysical |-> limit_low == '0 && limit_high == '0)
    else $error("unphysical result carries nonzero limits");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !unphysical |-> limit_low <= limit_high)
    else $error("lower limit above upper limit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(limit_low) && $stable(limit_high)
      && $stable(unphysical))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind dalitz_boundary_limits_core dbl_checker u_dbl_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (limits.valid),
  .out_ready  (limits.ready),
  .limit_low  (limits.limit_low),
  .limit_high (limits.limit_high),
  .unphysical (limits.unphysical)
);
